// ===== rtl/core/checked_integer_alu_assert.svh =====
// ----------------------------------------------------------------------------
// checked integer alu assertion macros
// shared property forms for the checker of the checked integer alu
// ----------------------------------------------------------------------------
`ifndef CHECKED_INTEGER_ALU_ASSERT_SVH
`define CHECKED_INTEGER_ALU_ASSERT_SVH

// same-cycle implication, quiet during reset
`define CIA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define CIA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/cia_pkg.sv =====
// ----------------------------------------------------------------------------
// cia_pkg
// types, codes and helper functions of the checked integer alu
// ----------------------------------------------------------------------------
`default_nettype none

package cia_pkg;

  // operand and result width, fixed by the item format
  localparam int unsigned DATA_W = 64;
  // width of the shared adder operands: one guard bit over the data
  localparam int unsigned UNIT_W = DATA_W + 1;
  // largest factorial argument that fits
  localparam logic [DATA_W-1:0] FACT_MAX = 64'd20;
  localparam logic [DATA_W-1:0] SIGN_BIT = 64'h8000_0000_0000_0000;

  // operation codes
  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_POW  = 3'd4;
  localparam logic [2:0] OP_FACT = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;
  localparam logic [1:0] ST_NEG  = 2'd3;

  typedef struct packed {
    logic [2:0]               op;
    logic signed [DATA_W-1:0] operand_a;
    logic signed [DATA_W-1:0] operand_b;
  } cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result;
    logic [1:0]               status;
  } rsp_t;

  // result item, value forced to zero on any error
  function automatic rsp_t mk(input logic [DATA_W-1:0] v, input logic [1:0] st);
    rsp_t r;
    r.result = (st == ST_OK) ? v : '0;
    r.status = st;
    return r;
  endfunction

  // magnitude of a two's complement value, most negative value maps to 2^63
  function automatic logic [DATA_W-1:0] mag(input logic [DATA_W-1:0] x);
    return x[DATA_W-1] ? (64'd0 - x) : x;
  endfunction

  // signed result from magnitude and sign, with range check
  function automatic rsp_t fit(input logic [DATA_W-1:0] m, input logic neg,
                               input logic ovf);
    rsp_t r;
    if (ovf || (neg && (m > SIGN_BIT)) || (!neg && m[DATA_W-1])) begin
      r = mk('0, ST_OVF);
    end else begin
      r = mk(neg ? (64'd0 - m) : m, ST_OK);
    end
    return r;
  endfunction

  // factorial table for arguments 0 to 20
  function automatic logic [DATA_W-1:0] fact(input logic [4:0] n);
    logic [DATA_W-1:0] f;
    unique case (n)
      5'd0:    f = 64'd1;
      5'd1:    f = 64'd1;
      5'd2:    f = 64'd2;
      5'd3:    f = 64'd6;
      5'd4:    f = 64'd24;
      5'd5:    f = 64'd120;
      5'd6:    f = 64'd720;
      5'd7:    f = 64'd5040;
      5'd8:    f = 64'd40320;
      5'd9:    f = 64'd362880;
      5'd10:   f = 64'd3628800;
      5'd11:   f = 64'd39916800;
      5'd12:   f = 64'd479001600;
      5'd13:   f = 64'd6227020800;
      5'd14:   f = 64'd87178291200;
      5'd15:   f = 64'd1307674368000;
      5'd16:   f = 64'd20922789888000;
      5'd17:   f = 64'd355687428096000;
      5'd18:   f = 64'd6402373705728000;
      5'd19:   f = 64'd121645100408832000;
      5'd20:   f = 64'd2432902008176640000;
      default: f = '0;
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cia_addsub.sv =====
// ----------------------------------------------------------------------------
// cia_addsub
// shared 65-bit adder with carry in and carry out, used for add, subtract,
// shift-add multiply steps and restoring divide steps
// ----------------------------------------------------------------------------
`default_nettype none

module cia_addsub (
  input  wire logic [cia_pkg::UNIT_W-1:0] x,
  input  wire logic [cia_pkg::UNIT_W-1:0] y,
  input  wire logic                       cin,
  output logic      [cia_pkg::UNIT_W:0]   sum
);

  // full width sum, top bit is the carry out
  assign sum = {1'b0, x} + {1'b0, y} + {{cia_pkg::UNIT_W{1'b0}}, cin};

endmodule

`default_nettype wire

// ===== rtl/core/checked_integer_alu.sv =====
// ----------------------------------------------------------------------------
// checked_integer_alu
// 64-bit signed alu with overflow, divide-by-zero and negative argument checks
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; exactly one result
// follows, shown on rsp for one cycle with done high, and it must be captured
// then since the block cannot be held off. Factorial, unused codes and
// commands settled at once (divide by zero, negative exponent, trivial powers,
// exponents above 63) give done in the cycle after the transfer; add and
// subtract first pass through the add state. Multiply and divide run 64
// shift-add or restoring steps through the one 65-bit adder. Power squares and
// multiplies over the six exponent bits, each multiply again 64 steps of that
// adder; these adder steps make up the bulk of every long command. A new
// command may be given in the cycle that done is high.
`default_nettype none

module checked_integer_alu (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire cia_pkg::cmd_t cmd,
  output logic               done,
  output cia_pkg::rsp_t      rsp
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ADD  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_POW  = 3'd4;
  localparam logic [2:0] S_PADV = 3'd5;

  localparam int unsigned CNT_W = $clog2(cia_pkg::DATA_W);
  localparam logic [CNT_W-1:0] STEP_LAST = CNT_W'(cia_pkg::DATA_W - 1);
  localparam logic [2:0] BIT_TOP = 3'd5;

  logic [2:0]                   state;
  logic [2:0]                   op_r;
  logic [cia_pkg::DATA_W-1:0]   hi;
  logic [cia_pkg::DATA_W-1:0]   lo;
  logic [cia_pkg::DATA_W-1:0]   mx;
  logic [cia_pkg::DATA_W-1:0]   acc;
  logic [cia_pkg::DATA_W-1:0]   base;
  logic [5:0]                   expo;
  logic [2:0]                   bit_idx;
  logic                         pow_sq;
  logic                         pow_base_mul;
  logic                         neg;
  logic [CNT_W-1:0]             cnt;

  logic [cia_pkg::UNIT_W-1:0]   ux;
  logic [cia_pkg::UNIT_W-1:0]   uy;
  logic                         ucin;
  logic [cia_pkg::UNIT_W:0]     usum;

  logic [cia_pkg::DATA_W-1:0]   hi_mul;
  logic [cia_pkg::DATA_W-1:0]   lo_mul;
  logic [cia_pkg::DATA_W-1:0]   hi_div;
  logic [cia_pkg::DATA_W-1:0]   lo_div;
  logic                         no_borrow;
  logic                         add_ovf;
  logic                         accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // operand selection for the shared adder
  always_comb begin
    unique case (state)
      S_ADD: begin
        ux   = {hi[cia_pkg::DATA_W-1], hi};
        uy   = (op_r == cia_pkg::OP_SUB) ? ~{lo[cia_pkg::DATA_W-1], lo}
                                         : {lo[cia_pkg::DATA_W-1], lo};
        ucin = (op_r == cia_pkg::OP_SUB);
      end
      S_DIV: begin
        ux   = {hi, lo[cia_pkg::DATA_W-1]};
        uy   = ~{1'b0, mx};
        ucin = 1'b1;
      end
      default: begin
        ux   = {1'b0, hi};
        uy   = lo[0] ? {1'b0, mx} : '0;
        ucin = 1'b0;
      end
    endcase
  end

  cia_addsub u_addsub (
    .x   (ux),
    .y   (uy),
    .cin (ucin),
    .sum (usum)
  );

  // next step values of the multiply and divide registers
  assign hi_mul    = usum[cia_pkg::UNIT_W-1:1];
  assign lo_mul    = {usum[0], lo[cia_pkg::DATA_W-1:1]};
  assign no_borrow = usum[cia_pkg::UNIT_W];
  assign hi_div    = no_borrow ? usum[cia_pkg::DATA_W-1:0]
                               : {hi[cia_pkg::DATA_W-2:0], lo[cia_pkg::DATA_W-1]};
  assign lo_div    = {lo[cia_pkg::DATA_W-2:0], no_borrow};
  assign add_ovf   = usum[cia_pkg::DATA_W] ^ usum[cia_pkg::DATA_W-1];

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_r <= cmd.op;
            unique case (cmd.op)
              cia_pkg::OP_ADD, cia_pkg::OP_SUB: begin
                hi    <= cmd.operand_a;
                lo    <= cmd.operand_b;
                state <= S_ADD;
              end
              cia_pkg::OP_MUL: begin
                mx    <= cia_pkg::mag(cmd.operand_a);
                lo    <= cia_pkg::mag(cmd.operand_b);
                hi    <= '0;
                neg   <= cmd.operand_a[cia_pkg::DATA_W-1] ^ cmd.operand_b[cia_pkg::DATA_W-1];
                cnt   <= '0;
                state <= S_MUL;
              end
              cia_pkg::OP_DIV: begin
                if (cmd.operand_b == '0) begin
                  done <= 1'b1;
                  rsp  <= cia_pkg::mk('0, cia_pkg::ST_DIV0);
                end else begin
                  mx    <= cia_pkg::mag(cmd.operand_b);
                  lo    <= cia_pkg::mag(cmd.operand_a);
                  hi    <= '0;
                  neg   <= cmd.operand_a[cia_pkg::DATA_W-1] ^ cmd.operand_b[cia_pkg::DATA_W-1];
                  cnt   <= '0;
                  state <= S_DIV;
                end
              end
              cia_pkg::OP_POW: begin
                // trivial and out-of-range powers are settled at once
                priority if (cmd.operand_b[cia_pkg::DATA_W-1]) begin
                  done <= 1'b1;
                  rsp  <= cia_pkg::mk('0, cia_pkg::ST_NEG);
                end else if (cmd.operand_b == '0) begin
                  done <= 1'b1;
                  rsp  <= cia_pkg::mk(64'd1, cia_pkg::ST_OK);
                end else if (cmd.operand_a == '0 || cmd.operand_a == 64'sd1) begin
                  done <= 1'b1;
                  rsp  <= cia_pkg::mk(cmd.operand_a, cia_pkg::ST_OK);
                end else if (cmd.operand_a == '1) begin
                  done <= 1'b1;
                  rsp  <= cia_pkg::mk(cmd.operand_b[0] ? '1 : 64'd1, cia_pkg::ST_OK);
                end else if (cmd.operand_b[cia_pkg::DATA_W-2:6] != '0) begin
                  done <= 1'b1;
                  rsp  <= cia_pkg::mk('0, cia_pkg::ST_OVF);
                end else begin
                  base    <= cia_pkg::mag(cmd.operand_a);
                  acc     <= 64'd1;
                  expo    <= cmd.operand_b[5:0];
                  bit_idx <= BIT_TOP;
                  pow_sq  <= 1'b1;
                  neg     <= cmd.operand_a[cia_pkg::DATA_W-1] & cmd.operand_b[0];
                  state   <= S_POW;
                end
              end
              cia_pkg::OP_FACT: begin
                done <= 1'b1;
                priority if (cmd.operand_a[cia_pkg::DATA_W-1]) begin
                  rsp <= cia_pkg::mk('0, cia_pkg::ST_NEG);
                end else if (cmd.operand_a > cia_pkg::FACT_MAX) begin
                  rsp <= cia_pkg::mk('0, cia_pkg::ST_OVF);
                end else begin
                  rsp <= cia_pkg::mk(cia_pkg::fact(cmd.operand_a[4:0]), cia_pkg::ST_OK);
                end
              end
              default: begin
                // unused codes give zero with ok status
                done <= 1'b1;
                rsp  <= cia_pkg::mk('0, cia_pkg::ST_OK);
              end
            endcase
          end
        end
        S_ADD: begin
          done  <= 1'b1;
          rsp   <= cia_pkg::mk(usum[cia_pkg::DATA_W-1:0],
                               add_ovf ? cia_pkg::ST_OVF : cia_pkg::ST_OK);
          state <= S_IDLE;
        end
        S_MUL: begin
          // one shift-add step per cycle, 128-bit product in hi and lo
          hi  <= hi_mul;
          lo  <= lo_mul;
          cnt <= cnt + 1'b1;
          if (cnt == STEP_LAST) begin
            if (op_r == cia_pkg::OP_MUL) begin
              done  <= 1'b1;
              rsp   <= cia_pkg::fit(lo_mul, neg, hi_mul != '0);
              state <= S_IDLE;
            end else if (hi_mul != '0) begin
              done  <= 1'b1;
              rsp   <= cia_pkg::mk('0, cia_pkg::ST_OVF);
              state <= S_IDLE;
            end else begin
              acc   <= lo_mul;
              state <= pow_base_mul ? S_PADV : S_POW;
            end
          end
        end
        S_DIV: begin
          // one restoring step per cycle, quotient shifts into lo
          hi  <= hi_div;
          lo  <= lo_div;
          cnt <= cnt + 1'b1;
          if (cnt == STEP_LAST) begin
            done  <= 1'b1;
            rsp   <= cia_pkg::fit(lo_div, neg, 1'b0);
            state <= S_IDLE;
          end
        end
        S_POW: begin
          // square the accumulator, then multiply by the base if the bit is set
          priority if (pow_sq) begin
            mx           <= acc;
            lo           <= acc;
            hi           <= '0;
            cnt          <= '0;
            pow_sq       <= 1'b0;
            pow_base_mul <= 1'b0;
            state        <= S_MUL;
          end else if (expo[bit_idx]) begin
            mx           <= base;
            lo           <= acc;
            hi           <= '0;
            cnt          <= '0;
            pow_base_mul <= 1'b1;
            state        <= S_MUL;
          end else begin
            state <= S_PADV;
          end
        end
        S_PADV: begin
          // move to the next lower exponent bit or finish
          if (bit_idx == '0) begin
            done  <= 1'b1;
            rsp   <= cia_pkg::fit(acc, neg, 1'b0);
            state <= S_IDLE;
          end else begin
            bit_idx <= bit_idx - 1'b1;
            pow_sq  <= 1'b1;
            state   <= S_POW;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cia_chk.sv =====
// ----------------------------------------------------------------------------
// cia_chk
// port-level checks of the checked integer alu, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "checked_integer_alu_assert.svh"

module cia_chk (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          start,
  input wire logic          busy,
  input wire cia_pkg::cmd_t cmd,
  input wire logic          done,
  input wire cia_pkg::rsp_t rsp
);

  // an accepted command either finishes at once or keeps the block busy
  `CIA_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done, "transfer lost after accept")

  // a result is only shown once the block is free again
  `CIA_ASSERT_NOW(a_done_free, done, !busy, "result shown while busy")

  // any error status carries a zero result
  `CIA_ASSERT_NOW(a_err_zero, done && (rsp.status != cia_pkg::ST_OK), rsp.result == '0, "error with nonzero result")

  // the end of a long command always delivers its result
  `CIA_ASSERT_NOW(a_fall_done, $fell(busy), done, "busy dropped without result")

endmodule

bind checked_integer_alu cia_chk u_cia_chk (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .cmd   (cmd),
  .done  (done),
  .rsp   (rsp)
);

`default_nettype wire

// ===== bench/checked_integer_alu_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// checked integer alu checker
// watches the command and result channels, works out each checked result on
// its own and compares it with what the alu returns, field by field
// ----------------------------------------------------------------------------

module checked_integer_alu_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          busy,
  input  cia_pkg::cmd_t cmd,
  input  logic          done,
  input  cia_pkg::rsp_t rsp,
  output int            fail_count,
  output int            pending
);

  import cia_pkg::*;

  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] S64_NEG1 = -64'sd1;

  // results still owed by the alu, oldest first
  rsp_t awaited_rsp[$];

  // result with the value cleared on any error
  function automatic rsp_t make_rsp(input logic signed [63:0] v, input logic [1:0] st);
    rsp_t r;
    r.result = (st == ST_OK) ? v : '0;
    r.status = st;
    return r;
  endfunction

  // exact product through a double-width multiply, then a range check
  function automatic rsp_t checked_mul(input logic signed [63:0] a,
                                       input logic signed [63:0] b);
    logic signed [127:0] p;
    p = a * b;
    if ((p[127:63] == '0) || (p[127:63] == '1)) return make_rsp(p[63:0], ST_OK);
    return make_rsp('0, ST_OVF);
  endfunction

  // repeated multiply; magnitudes only grow so the first overflow is final
  function automatic rsp_t checked_pow(input logic signed [63:0] base,
                                       input logic signed [63:0] ex);
    rsp_t acc;
    if (ex < 0) return make_rsp('0, ST_NEG);
    if (ex == 0) return make_rsp(64'sd1, ST_OK);
    if (base == 0 || base == 1) return make_rsp(base, ST_OK);
    if (base == S64_NEG1) return make_rsp(ex[0] ? S64_NEG1 : 64'sd1, ST_OK);
    if (ex > 63) return make_rsp('0, ST_OVF);
    acc = make_rsp(64'sd1, ST_OK);
    for (int i = 0; i < int'(ex); i++) begin
      acc = checked_mul(acc.result, base);
      if (acc.status != ST_OK) return acc;
    end
    return acc;
  endfunction

  // factorial by running product, limited to arguments that fit
  function automatic rsp_t checked_fact(input logic signed [63:0] n);
    logic [63:0] f;
    if (n < 0) return make_rsp('0, ST_NEG);
    if (n > 20) return make_rsp('0, ST_OVF);
    f = 64'd1;
    for (int k = 2; k <= int'(n); k++) f = f * 64'(k);
    return make_rsp(f, ST_OK);
  endfunction

  // checked result of one command
  function automatic rsp_t checked_outcome(input cmd_t c);
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic signed [63:0] s;
    a = c.operand_a;
    b = c.operand_b;
    case (c.op)
      OP_ADD: begin
        s = a + b;
        if ((~(a ^ b) & (a ^ s)) < 0) return make_rsp('0, ST_OVF);
        return make_rsp(s, ST_OK);
      end
      OP_SUB: begin
        s = a - b;
        if (((a ^ b) & (a ^ s)) < 0) return make_rsp('0, ST_OVF);
        return make_rsp(s, ST_OK);
      end
      OP_MUL:  return checked_mul(a, b);
      OP_DIV: begin
        if (b == 0) return make_rsp('0, ST_DIV0);
        if (a == S64_MIN && b == S64_NEG1) return make_rsp('0, ST_OVF);
        return make_rsp(a / b, ST_OK);
      end
      OP_POW:  return checked_pow(a, b);
      OP_FACT: return checked_fact(a);
      default: return make_rsp('0, ST_OK);
    endcase
  endfunction

  // a result ends the oldest command first, so pop before a new push
  always @(posedge clk) begin : watch
    rsp_t want;
    int   fails;
    fails = fail_count;
    if (rst) begin
      awaited_rsp.delete();
      fails = 0;
    end else begin
      if (done === 1'b1) begin
        if (awaited_rsp.size() == 0) begin
          $error("result with none awaited: result %0d status %0d", rsp.result, rsp.status);
          fails++;
        end else begin
          want = awaited_rsp.pop_front();
          if (rsp.result !== want.result) begin
            $error("result: expected %0d, got %0d", want.result, rsp.result);
            fails++;
          end
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            fails++;
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        awaited_rsp.push_back(checked_outcome(cmd));
      end
    end
    fail_count <= fails;
    pending    <= awaited_rsp.size();
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// checked integer alu testbench
// edge cases of every operation first, then random commands under three
// sender idle profiles; the checker beside the alu judges every result
// ----------------------------------------------------------------------------

module tb;

  import cia_pkg::*;

  localparam logic signed [63:0] S64_MIN  = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] S64_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_NEG1 = -64'sd1;
  // opcodes with no operation behind them
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int RANDOM_PER_PHASE = 217;

  logic  clk   = 1'b0;
  logic  rst   = 1'b1;
  logic  start = 1'b0;
  cmd_t  cmd   = '0;
  logic  busy;
  logic  done;
  rsp_t  rsp;
  int    fail_count;
  int    pending;
  int    op_count[8];

  checked_integer_alu u_top (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .done  (done),
    .rsp   (rsp)
  );

  checked_integer_alu_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .done       (done),
    .rsp        (rsp),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // run limit, far above the slowest correct run
  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic cmd_t mk_cmd(input logic [2:0] op, input logic signed [63:0] a,
                                  input logic signed [63:0] b);
    cmd_t c;
    c.op        = op;
    c.operand_a = a;
    c.operand_b = b;
    return c;
  endfunction

  // operand drawn from a mix of full range, small, boundary and power-of-two values
  function automatic logic signed [63:0] rand_operand();
    logic signed [63:0] v;
    logic [31:0]        r;
    r = $urandom;
    case ($urandom_range(0, 5))
      0: v = {$urandom, $urandom};
      1: v = 64'($urandom_range(0, 200)) - 64'd100;
      2: begin
        case ($urandom_range(0, 6))
          0:       v = S64_MIN;
          1:       v = S64_MAX;
          2:       v = S64_MIN + 1;
          3:       v = S64_MAX - 1;
          4:       v = '0;
          5:       v = 64'sd1;
          default: v = S64_NEG1;
        endcase
      end
      3: v = {{32{r[31]}}, r};
      4: begin
        v = 64'sd1 <<< $urandom_range(0, 63);
        if ($urandom_range(0, 1)) v = -v;
        if ($urandom_range(0, 1)) v = v - 1;
      end
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  // random command, shaped per operation so that every path is reached
  function automatic cmd_t rand_cmd();
    int                 sel;
    logic [2:0]         op;
    logic signed [63:0] a;
    logic signed [63:0] b;
    sel = $urandom_range(0, 15);
    a   = rand_operand();
    b   = rand_operand();
    if (sel < 3) begin
      op = OP_ADD;
    end else if (sel < 6) begin
      op = OP_SUB;
    end else if (sel < 9) begin
      op = OP_MUL;
    end else if (sel < 11) begin
      op = OP_DIV;
      if ($urandom_range(0, 9) == 0) b = '0;
    end else if (sel < 13) begin
      op = OP_POW;
      if ($urandom_range(0, 3) != 0) a = 64'($urandom_range(0, 24)) - 64'd12;
      case ($urandom_range(0, 9))
        0:       b = {$urandom, $urandom};
        1:       b = 64'($urandom_range(64, 200));
        default: b = 64'($urandom_range(0, 63));
      endcase
    end else if (sel < 15) begin
      op = OP_FACT;
      if ($urandom_range(0, 4) != 0) a = 64'($urandom_range(0, 27)) - 64'd3;
    end else begin
      op = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
    end
    return mk_cmd(op, a, b);
  endfunction

  // hold the command until the alu takes it
  task automatic send(input cmd_t c);
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    op_count[c.op]++;
  endtask

  // sender gap, with the given chance in a hundred
  task automatic maybe_idle(input int pct);
    if ($urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  endtask

  // stop sending until every awaited result is back
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic random_phase(input int pct);
    for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
      send(rand_cmd());
      maybe_idle(pct);
    end
    drain();
  endtask

  // stimulus and verdict
  initial begin
    cmd_t directed[$];
    foreach (op_count[i]) op_count[i] = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // edge cases of every operation
    directed.push_back(mk_cmd(OP_ADD, S64_MAX, 64'sd1));
    directed.push_back(mk_cmd(OP_ADD, S64_MIN, S64_NEG1));
    directed.push_back(mk_cmd(OP_ADD, S64_MIN, S64_MAX));
    directed.push_back(mk_cmd(OP_SUB, '0, S64_MIN));
    directed.push_back(mk_cmd(OP_SUB, S64_NEG1, S64_MIN));
    directed.push_back(mk_cmd(OP_SUB, S64_MIN, 64'sd1));
    directed.push_back(mk_cmd(OP_MUL, S64_MIN, S64_NEG1));
    directed.push_back(mk_cmd(OP_MUL, S64_MIN, 64'sd1));
    directed.push_back(mk_cmd(OP_MUL, 64'sh1_0000_0000, -64'sh8000_0000));
    directed.push_back(mk_cmd(OP_MUL, S64_MAX, S64_MAX));
    directed.push_back(mk_cmd(OP_DIV, S64_MAX, '0));
    directed.push_back(mk_cmd(OP_DIV, S64_MIN, S64_NEG1));
    directed.push_back(mk_cmd(OP_DIV, -64'sd7, 64'sd2));
    directed.push_back(mk_cmd(OP_DIV, S64_MIN, S64_MIN));
    directed.push_back(mk_cmd(OP_POW, 64'sd3, S64_NEG1));
    directed.push_back(mk_cmd(OP_POW, '0, '0));
    directed.push_back(mk_cmd(OP_POW, 64'sd2, 64'sd62));
    directed.push_back(mk_cmd(OP_POW, 64'sd2, 64'sd63));
    directed.push_back(mk_cmd(OP_POW, -64'sd2, 64'sd63));
    directed.push_back(mk_cmd(OP_POW, S64_NEG1, S64_MAX));
    directed.push_back(mk_cmd(OP_POW, 64'sd3, 64'sd40));
    directed.push_back(mk_cmd(OP_POW, 64'sd5, 64'sd64));
    directed.push_back(mk_cmd(OP_FACT, 64'sd20, S64_MIN));
    directed.push_back(mk_cmd(OP_FACT, 64'sd21, '0));
    directed.push_back(mk_cmd(OP_FACT, S64_MIN, S64_MAX));
    directed.push_back(mk_cmd(OP_SPARE_LO, S64_MAX, S64_MIN));
    directed.push_back(mk_cmd(OP_SPARE_HI, S64_NEG1, S64_NEG1));
    foreach (directed[i]) send(directed[i]);
    drain();

    // random commands under the three sender idle profiles
    random_phase(27);
    random_phase(76);
    random_phase(0);

    repeat (20) @(posedge clk);
    $display("ran %0d commands: add %0d, sub %0d, mul %0d, div %0d, pow %0d, fact %0d, spare %0d",
             op_count.sum(), op_count[OP_ADD], op_count[OP_SUB], op_count[OP_MUL],
             op_count[OP_DIV], op_count[OP_POW], op_count[OP_FACT],
             op_count[OP_SPARE_LO] + op_count[OP_SPARE_HI]);
    $display("edge cases first, then random commands with sender gaps of 27, 76 and 0 percent");
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
